### rtl/tccs_pkg.sv
// types, constants and microcode program of the text console engine
`default_nettype none

package tccs_pkg;

  localparam int unsigned COLS_W = 8;
  localparam int unsigned ROWS_W = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 13;
  localparam int unsigned POS_W  = 13;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned UPC_W  = 5;

  localparam logic [COLS_W-1:0] COLUMNS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET    = 7'd25;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [CELL_W-1:0] CHAR_ATTR  = 16'h0F00;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
  localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0000;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic              cursor_written;
    logic [CELL_W-1:0] cell_value;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_FETCH,
    OP_MUL_POS,
    OP_MUL_SPAN,
    OP_PUT_CHAR,
    OP_NEWLINE,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_FILL,
    OP_EMIT,
    OP_READ_CELL,
    OP_READ_VAL,
    OP_COL_ZERO,
    OP_COL_DEC
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_BUSY,
    C_NO_INPUT,
    C_IS_READ,
    C_IS_LF,
    C_IS_CR,
    C_IS_BS,
    C_NO_WRAP,
    C_NO_SCROLL,
    C_COPY_DONE,
    C_FILL_BUSY,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_e op;
  } seq_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_read;
    logic is_lf;
    logic is_cr;
    logic is_bs;
    logic clr_busy;
    logic no_wrap;
    logic no_scroll;
    logic copy_done;
    logic fill_busy;
    logic out_busy;
  } seq_status_t;

  // program entry points
  localparam logic [UPC_W-1:0] ST_CLEAR     = 5'd0;
  localparam logic [UPC_W-1:0] ST_FETCH     = 5'd1;
  localparam logic [UPC_W-1:0] ST_DEC_READ  = 5'd2;
  localparam logic [UPC_W-1:0] ST_DEC_LF    = 5'd3;
  localparam logic [UPC_W-1:0] ST_DEC_CR    = 5'd4;
  localparam logic [UPC_W-1:0] ST_DEC_BS    = 5'd5;
  localparam logic [UPC_W-1:0] ST_PUT_ADDR  = 5'd6;
  localparam logic [UPC_W-1:0] ST_PUT_WRITE = 5'd7;
  localparam logic [UPC_W-1:0] ST_NEWLINE   = 5'd8;
  localparam logic [UPC_W-1:0] ST_SPAN      = 5'd9;
  localparam logic [UPC_W-1:0] ST_COPY_TEST = 5'd10;
  localparam logic [UPC_W-1:0] ST_COPY_RD   = 5'd11;
  localparam logic [UPC_W-1:0] ST_COPY_WR   = 5'd12;
  localparam logic [UPC_W-1:0] ST_FILL      = 5'd13;
  localparam logic [UPC_W-1:0] ST_POS       = 5'd14;
  localparam logic [UPC_W-1:0] ST_EMIT      = 5'd15;
  localparam logic [UPC_W-1:0] ST_RETURN    = 5'd16;
  localparam logic [UPC_W-1:0] ST_READ      = 5'd17;
  localparam logic [UPC_W-1:0] ST_READ_VAL  = 5'd18;
  localparam logic [UPC_W-1:0] ST_CR        = 5'd19;
  localparam logic [UPC_W-1:0] ST_BS        = 5'd20;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] step);
    ucode_t w;
    unique case (step)
      ST_CLEAR:     w = '{OP_CLEAR,     C_CLR_BUSY,  ST_CLEAR};
      ST_FETCH:     w = '{OP_FETCH,     C_NO_INPUT,  ST_FETCH};
      ST_DEC_READ:  w = '{OP_NOP,       C_IS_READ,   ST_READ};
      ST_DEC_LF:    w = '{OP_NOP,       C_IS_LF,     ST_NEWLINE};
      ST_DEC_CR:    w = '{OP_NOP,       C_IS_CR,     ST_CR};
      ST_DEC_BS:    w = '{OP_NOP,       C_IS_BS,     ST_BS};
      ST_PUT_ADDR:  w = '{OP_MUL_POS,   C_NEVER,     ST_CLEAR};
      ST_PUT_WRITE: w = '{OP_PUT_CHAR,  C_NO_WRAP,   ST_POS};
      ST_NEWLINE:   w = '{OP_NEWLINE,   C_NO_SCROLL, ST_POS};
      ST_SPAN:      w = '{OP_MUL_SPAN,  C_NEVER,     ST_CLEAR};
      ST_COPY_TEST: w = '{OP_NOP,       C_COPY_DONE, ST_FILL};
      ST_COPY_RD:   w = '{OP_COPY_RD,   C_NEVER,     ST_CLEAR};
      ST_COPY_WR:   w = '{OP_COPY_WR,   C_ALWAYS,    ST_COPY_TEST};
      ST_FILL:      w = '{OP_FILL,      C_FILL_BUSY, ST_FILL};
      ST_POS:       w = '{OP_MUL_POS,   C_NEVER,     ST_CLEAR};
      ST_EMIT:      w = '{OP_EMIT,      C_OUT_BUSY,  ST_EMIT};
      ST_RETURN:    w = '{OP_NOP,       C_ALWAYS,    ST_FETCH};
      ST_READ:      w = '{OP_READ_CELL, C_NEVER,     ST_CLEAR};
      ST_READ_VAL:  w = '{OP_READ_VAL,  C_ALWAYS,    ST_POS};
      ST_CR:        w = '{OP_COL_ZERO,  C_ALWAYS,    ST_POS};
      ST_BS:        w = '{OP_COL_DEC,   C_ALWAYS,    ST_POS};
      default:      w = '{OP_NOP,       C_ALWAYS,    ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/tccs_frame_mem.sv
// frame store: one write port, one read port with registered data
`default_nettype none

module tccs_frame_mem #(
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [tccs_pkg::CELL_W-1:0] wdata_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [tccs_pkg::CELL_W-1:0] rdata_o
);
  import tccs_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/tccs_useq.sv
// microcode sequencer: step counter, program rom and jump condition select
`default_nettype none

module tccs_useq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tccs_pkg::seq_status_t status_i,
  output tccs_pkg::seq_ctrl_t        ctrl_o
);
  import tccs_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           word;
  logic             take;

  assign word = ucode_rom(upc_q);

  always_comb begin
    unique case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_CLR_BUSY:  take = status_i.clr_busy;
      C_NO_INPUT:  take = !status_i.in_valid;
      C_IS_READ:   take = status_i.is_read;
      C_IS_LF:     take = status_i.is_lf;
      C_IS_CR:     take = status_i.is_cr;
      C_IS_BS:     take = status_i.is_bs;
      C_NO_WRAP:   take = status_i.no_wrap;
      C_NO_SCROLL: take = status_i.no_scroll;
      C_COPY_DONE: take = status_i.copy_done;
      C_FILL_BUSY: take = status_i.fill_busy;
      C_OUT_BUSY:  take = status_i.out_busy;
      default:     take = 1'b1;
    endcase
  end

  assign upc_d     = take ? word.target : upc_q + UPC_W'(1);
  assign ctrl_o.op = word.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/tccs_dpath.sv
// datapath: config and cursor registers, shared multiplier, store access, result register
`default_nettype none

module tccs_dpath #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS = 64,
  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [tccs_pkg::COLS_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire tccs_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output tccs_pkg::out_item_t              out_data_o,
  input  wire tccs_pkg::seq_ctrl_t         ctrl_i,
  output tccs_pkg::seq_status_t            status_o,
  output logic                             mem_we_o,
  output logic      [AW-1:0]               mem_waddr_o,
  output logic      [tccs_pkg::CELL_W-1:0] mem_wdata_o,
  output logic      [AW-1:0]               mem_raddr_o,
  input  wire logic [tccs_pkg::CELL_W-1:0] mem_rdata_i
);
  import tccs_pkg::*;

  localparam int unsigned CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned NCW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned NRW = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW  = AW + 1;

  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic              kind_q, kind_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              wr_q, wr_d;
  logic [CELL_W-1:0] val_q, val_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic [PW-1:0]     i_q, i_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              ok_q, ok_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [NCW-1:0]    nc;
  logic [NRW-1:0]    nr;
  logic [NRW-1:0]    mul_a;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic [PW-1:0]     i_plus_nc;
  logic              out_busy;

  // out-of-range settings saturate into the legal span
  always_comb begin
    priority if (cols_q == '0) begin
      nc = NCW'(1);
    end else if (32'(cols_q) > MAX_COLUMNS) begin
      nc = NCW'(MAX_COLUMNS);
    end else begin
      nc = NCW'(cols_q);
    end
    priority if (rows_q == '0) begin
      nr = NRW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_q);
    end
  end

  assign col_inc   = (CW+1)'(col_q) + (CW+1)'(1);
  assign row_inc   = (RW+1)'(row_q) + (RW+1)'(1);
  assign i_plus_nc = i_q + PW'(nc);
  assign out_busy  = out_valid_q && out_stall_i;
  assign mul_a     = (ctrl_i.op == OP_MUL_SPAN) ? nr - NRW'(1) : NRW'(row_q);

  assign in_stall_o = (ctrl_i.op != OP_FETCH);

  // wrap and scroll are judged from the cursor before the step updates it
  always_comb begin
    status_o.in_valid  = in_valid_i;
    status_o.is_read   = kind_q;
    status_o.is_lf     = (char_q == CODE_LF);
    status_o.is_cr     = (char_q == CODE_CR);
    status_o.is_bs     = (char_q == CODE_BS);
    status_o.clr_busy  = (clr_q != AW'(DEPTH - 1));
    status_o.no_wrap   = !(32'(col_inc) >= 32'(nc));
    status_o.no_scroll = !(32'(row_inc) >= 32'(nr));
    status_o.copy_done = (i_q >= prod_q);
    status_o.fill_busy = ((i_q + PW'(1)) < (prod_q + PW'(nc)));
    status_o.out_busy  = out_busy;
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    kind_d      = kind_q;
    char_d      = char_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    val_d       = val_q;
    prod_d      = prod_q;
    i_d         = i_q;
    clr_d       = clr_q;
    ok_d        = ok_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(i_q);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = AW'(i_plus_nc);
    unique case (ctrl_i.op)
      OP_NOP: begin
      end
      OP_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = CLEAR_CELL;
        clr_d       = clr_q + AW'(1);
      end
      OP_FETCH: begin
        kind_d = in_data_i.kind;
        char_d = in_data_i.char_code;
        idx_d  = in_data_i.cell_index;
        wr_d   = 1'b0;
        val_d  = '0;
      end
      OP_MUL_POS: begin
        prod_d = PW'(mul_a) * PW'(nc) + PW'(col_q);
      end
      OP_MUL_SPAN: begin
        prod_d = PW'(mul_a) * PW'(nc);
        i_d    = '0;
      end
      OP_PUT_CHAR: begin
        mem_we_o    = (prod_q < PW'(DEPTH));
        mem_waddr_o = AW'(prod_q);
        mem_wdata_o = CHAR_ATTR | CELL_W'(char_q);
        col_d       = CW'(col_inc);
        wr_d        = 1'b1;
      end
      OP_NEWLINE: begin
        col_d    = '0;
        wr_d     = 1'b1;
        row_d    = (32'(row_inc) >= 32'(nr)) ? RW'(nr - NRW'(1)) : RW'(row_inc);
      end
      OP_COPY_RD: begin
        ok_d = (i_plus_nc < PW'(DEPTH));
      end
      OP_COPY_WR: begin
        mem_we_o = ok_q;
        i_d      = i_q + PW'(1);
      end
      OP_FILL: begin
        mem_we_o    = (i_q < PW'(DEPTH));
        mem_wdata_o = BLANK_CELL;
        i_d         = i_q + PW'(1);
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_d          = 1'b1;
          out_d.cursor_pos     = POS_W'(prod_q);
          out_d.cursor_written = wr_q;
          out_d.cell_value     = val_q;
        end
      end
      OP_READ_CELL: begin
        mem_raddr_o = AW'(idx_q);
        ok_d        = (32'(idx_q) < DEPTH);
      end
      OP_READ_VAL: begin
        val_d = ok_q ? mem_rdata_i : '0;
      end
      OP_COL_ZERO: begin
        col_d = '0;
        wr_d  = 1'b1;
      end
      OP_COL_DEC: begin
        if (col_q != '0) begin
          col_d = col_q - CW'(1);
          wr_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= COLUMNS_RESET;
      rows_q      <= ROWS_RESET;
      col_q       <= '0;
      row_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_COLUMNS)) begin
        cols_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_ROWS)) begin
        rows_q <= cfg_wdata_i[ROWS_W-1:0];
      end
      col_q       <= col_d;
      row_q       <= row_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    char_q   <= char_d;
    idx_q    <= idx_d;
    wr_q     <= wr_d;
    val_q    <= val_d;
    prod_q   <= prod_d;
    i_q      <= i_d;
    ok_q     <= ok_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/text_console_cursor_scroll_core.sv
// top level of the text console engine
`default_nettype none

// Text console engine: put items write characters at the cursor and move it, read items
// return one frame cell, and each item gives one result with the linear cursor position.
// Control runs from a microcode program over one frame memory with a single write and a
// single registered read port, so items are handled one at a time. A scroll moves every
// row but the top one up by one row, each copied cell needing a memory read and a write,
// and then fills the bottom row with blanks. A result that waits on out_stall_i holds
// the sequencer once the next result is ready to be emitted. After reset a clearing pass
// writes every cell to zero before the first input transfer; configuration writes are
// taken at any time and should be issued only while idle.
module text_console_cursor_scroll_core #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [tccs_pkg::COLS_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire tccs_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output tccs_pkg::out_item_t              out_data_o
);
  import tccs_pkg::*;

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  seq_ctrl_t         ctrl;
  seq_status_t       status;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tccs_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  tccs_dpath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tccs_frame_mem #(
    .DEPTH (DEPTH)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
